[rtl/resource_admission_table_top_assert.svh]
// Assertion macros shared by the checker of the admission table.
// Both forms are clocked on clk and are switched off while arst_n is low.
`ifndef RESOURCE_ADMISSION_TABLE_TOP_ASSERT_SVH
`define RESOURCE_ADMISSION_TABLE_TOP_ASSERT_SVH
// Same-cycle implication.
`define RAT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("admission table assertion failed");
// Next-cycle implication.
`define RAT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("admission table assertion failed");
`endif

[rtl/rat_pkg.sv]
`default_nettype none
package rat_pkg;

	localparam int UNIT_W   = 16;
	localparam int APP_ID_W = 6;
	localparam int APP_IDS  = 2 ** APP_ID_W;
	localparam int DATA_W   = 32;
	localparam int PADDR_W  = 4;

	// Operation codes of a request.
	localparam logic OP_START = 1'b0;
	localparam logic OP_STOP  = 1'b1;

	// Result status codes.
	localparam logic [1:0] STATUS_GRANTED      = 2'd0;
	localparam logic [1:0] STATUS_INSUFFICIENT = 2'd1;
	localparam logic [1:0] STATUS_RELEASED     = 2'd2;
	localparam logic [1:0] STATUS_NO_ALLOC     = 2'd3;

	// Configuration register indexes (byte address divided by four).
	localparam logic [1:0] REG_RAM_LIMIT  = 2'd0;
	localparam logic [1:0] REG_DISK_LIMIT = 2'd1;
	localparam logic [1:0] REG_CPU_LIMIT  = 2'd2;

	// Resource order used by the shared check unit.
	localparam logic [1:0] RES_RAM  = 2'd0;
	localparam logic [1:0] RES_DISK = 2'd1;
	localparam logic [1:0] RES_CPU  = 2'd2;

	typedef struct packed {
		logic                operation;
		logic [APP_ID_W-1:0] app_id;
		logic [UNIT_W-1:0]   ram_demand;
		logic [UNIT_W-1:0]   disk_demand;
		logic [UNIT_W-1:0]   cpu_demand;
	} req_t;

	typedef struct packed {
		logic              forward;
		logic [1:0]        status;
		logic [UNIT_W-1:0] ram_in_use;
		logic [UNIT_W-1:0] disk_in_use;
		logic [UNIT_W-1:0] cpu_in_use;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_COMMIT
	} state_t;

endpackage
`default_nettype wire

[rtl/rat_ram.sv]
`default_nettype none
module rat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

[rtl/resource_admission_table_top.sv]
// A request accepted while idle has its three budgets checked one after another in a single
// shared add/subtract-and-compare unit; a success is written to the table, and the result is
// registered; busy stays high meanwhile, so no new request is taken until the last is through.
// Reset: arst_n clears limits, totals and control; a clearing pass then invalidates every
// table entry, and busy stays high until it has finished.
// The receiver cannot stall: done marks each result for exactly one cycle.
`default_nettype none
module resource_admission_table_top #(
	parameter int APP_SLOTS = 64,
	parameter int UNIT_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rat_pkg::PADDR_W-1:0]  paddr,
	input  logic [rat_pkg::DATA_W-1:0]   pwdata,
	output logic [rat_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	input  logic                         start,
	output logic                         busy,
	input  rat_pkg::req_t                req,
	output logic                         done,
	output rat_pkg::rsp_t                rsp
);

	// Table address width, the width of a stored demand (never more than the request
	// field), the width of the check unit (one bit more than the wider operand) and the
	// table word: three stored amounts with the valid flag on top.
	localparam int ADDR_W  = $clog2(APP_SLOTS);
	localparam int DEM_W   = (UNIT_BITS < rat_pkg::UNIT_W) ? UNIT_BITS : rat_pkg::UNIT_W;
	localparam int SUM_W   = ((UNIT_BITS > rat_pkg::UNIT_W) ? UNIT_BITS : rat_pkg::UNIT_W) + 1;
	localparam int ENTRY_W = 3 * DEM_W + 1;

	// Sequencer state.
	rat_pkg::state_t state_q, state_d;
	logic [ADDR_W-1:0] clr_cnt_q;
	logic [1:0]        res_idx_q;
	logic              fits_q;
	logic              done_q;

	// Control decoded from the state.
	logic accept;
	logic in_clear;
	logic in_check;
	logic in_commit;

	// Configuration registers.
	logic [rat_pkg::UNIT_W-1:0] ram_limit_q, disk_limit_q, cpu_limit_q;
	logic                       cfg_write;

	// Running totals and the candidate totals built up by the check unit.
	logic [UNIT_BITS-1:0] ram_total_q, disk_total_q, cpu_total_q;
	logic [UNIT_BITS-1:0] ram_cand_q, disk_cand_q, cpu_cand_q;

	// The request held while it is worked on.
	logic              op_q;
	logic [ADDR_W-1:0] slot_q;
	logic [DEM_W-1:0]  ram_dem_q, disk_dem_q, cpu_dem_q;

	// Allocation table port.
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	logic               entry_valid;

	// Shared check unit.
	logic [SUM_W-1:0] op_total, op_other, op_limit;
	logic [SUM_W-1:0] unit_sum, unit_diff, unit_res;
	logic             unit_fit;

	// Commit decision.
	logic          success;
	rat_pkg::rsp_t rsp_d;
	rat_pkg::rsp_t rsp_q;

	// The application id is taken modulo the table depth. The id is only six bits
	// wide, so a constant lookup table built at elaboration does the reduction.
	logic [ADDR_W-1:0] slot_lut [rat_pkg::APP_IDS];
	for (genvar gi = 0; gi < rat_pkg::APP_IDS; gi++) begin : g_slot
		localparam int SLOT = gi % APP_SLOTS;
		assign slot_lut[gi] = ADDR_W'(SLOT);
	end

	// ------------------------------------------------------------------
	// Configuration port. Writes complete in the access phase; pready is
	// tied high so there are never wait states.
	// ------------------------------------------------------------------
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		case (paddr[3:2])
			rat_pkg::REG_RAM_LIMIT:  prdata = rat_pkg::DATA_W'(ram_limit_q);
			rat_pkg::REG_DISK_LIMIT: prdata = rat_pkg::DATA_W'(disk_limit_q);
			rat_pkg::REG_CPU_LIMIT:  prdata = rat_pkg::DATA_W'(cpu_limit_q);
			default:                 prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer: after reset the whole table is swept once to clear the
	// valid flags. A request then runs IDLE -> CHECK (one step per
	// resource) -> COMMIT -> IDLE.
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			rat_pkg::ST_CLEAR: begin
				if (clr_cnt_q == ADDR_W'(APP_SLOTS - 1)) begin
					state_d = rat_pkg::ST_IDLE;
				end
			end
			rat_pkg::ST_IDLE: begin
				if (start) begin
					state_d = rat_pkg::ST_CHECK;
				end
			end
			rat_pkg::ST_CHECK: begin
				if (res_idx_q == rat_pkg::RES_CPU) begin
					state_d = rat_pkg::ST_COMMIT;
				end
			end
			rat_pkg::ST_COMMIT: state_d = rat_pkg::ST_IDLE;
			default:            state_d = rat_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		busy      = 1'b1;
		in_clear  = 1'b0;
		in_check  = 1'b0;
		in_commit = 1'b0;
		case (state_q)
			rat_pkg::ST_CLEAR:  in_clear  = 1'b1;
			rat_pkg::ST_IDLE:   busy      = 1'b0;
			rat_pkg::ST_CHECK:  in_check  = 1'b1;
			rat_pkg::ST_COMMIT: in_commit = 1'b1;
			default:            busy      = 1'b1;
		endcase
	end

	assign accept = start && !busy;

	// ------------------------------------------------------------------
	// Allocation table. The read address follows the incoming request
	// while idle, so the entry is already in the read register during the
	// first check cycle, and it then stays on the held slot.
	// ------------------------------------------------------------------
	assign ram_raddr   = busy ? slot_q : slot_lut[req.app_id];
	assign entry_valid = ram_rdata[ENTRY_W-1];

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_q;
		ram_wdata = '0;
		if (in_clear) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
		end else if (in_commit && success) begin
			ram_we = 1'b1;
			// A release writes an all-zero word: valid cleared, amounts zero.
			if (op_q == rat_pkg::OP_START) begin
				ram_wdata = {1'b1, cpu_dem_q, disk_dem_q, ram_dem_q};
			end
		end
	end

	rat_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(APP_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------
	// Shared check unit. For a start it adds the demand to the total and
	// compares the sum with the limit; for a stop it subtracts the stored
	// amount, clamped at zero. The resource is chosen by res_idx_q.
	// ------------------------------------------------------------------
	always_comb begin
		op_total = '0;
		op_other = '0;
		op_limit = '0;
		case (res_idx_q)
			rat_pkg::RES_RAM: begin
				op_total = SUM_W'(ram_total_q);
				op_limit = SUM_W'(ram_limit_q);
				op_other = (op_q == rat_pkg::OP_STOP) ? SUM_W'(ram_rdata[DEM_W-1:0])
				                                      : SUM_W'(ram_dem_q);
			end
			rat_pkg::RES_DISK: begin
				op_total = SUM_W'(disk_total_q);
				op_limit = SUM_W'(disk_limit_q);
				op_other = (op_q == rat_pkg::OP_STOP) ? SUM_W'(ram_rdata[2*DEM_W-1:DEM_W])
				                                      : SUM_W'(disk_dem_q);
			end
			rat_pkg::RES_CPU: begin
				op_total = SUM_W'(cpu_total_q);
				op_limit = SUM_W'(cpu_limit_q);
				op_other = (op_q == rat_pkg::OP_STOP) ? SUM_W'(ram_rdata[3*DEM_W-1:2*DEM_W])
				                                      : SUM_W'(cpu_dem_q);
			end
			default: begin
				op_total = '0;
			end
		endcase
	end

	assign unit_sum  = op_total + op_other;
	assign unit_diff = op_total - op_other;
	assign unit_fit  = (unit_sum <= op_limit);

	always_comb begin
		if (op_q == rat_pkg::OP_STOP) begin
			unit_res = (op_total < op_other) ? '0 : unit_diff;
		end else begin
			unit_res = unit_sum;
		end
	end

	// ------------------------------------------------------------------
	// Commit: a start succeeds when every budget fits, a stop when the
	// entry exists. Refused requests report the unchanged totals.
	// ------------------------------------------------------------------
	always_comb begin
		success = (op_q == rat_pkg::OP_STOP) ? entry_valid : fits_q;
		rsp_d.forward = success;
		if (op_q == rat_pkg::OP_STOP) begin
			rsp_d.status = success ? rat_pkg::STATUS_RELEASED : rat_pkg::STATUS_NO_ALLOC;
		end else begin
			rsp_d.status = success ? rat_pkg::STATUS_GRANTED : rat_pkg::STATUS_INSUFFICIENT;
		end
		rsp_d.ram_in_use  = rat_pkg::UNIT_W'(success ? ram_cand_q : ram_total_q);
		rsp_d.disk_in_use = rat_pkg::UNIT_W'(success ? disk_cand_q : disk_total_q);
		rsp_d.cpu_in_use  = rat_pkg::UNIT_W'(success ? cpu_cand_q : cpu_total_q);
	end

	// ------------------------------------------------------------------
	// Control registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= rat_pkg::ST_CLEAR;
			clr_cnt_q    <= '0;
			res_idx_q    <= rat_pkg::RES_RAM;
			fits_q       <= 1'b1;
			done_q       <= 1'b0;
			op_q         <= rat_pkg::OP_START;
			ram_limit_q  <= '0;
			disk_limit_q <= '0;
			cpu_limit_q  <= '0;
			ram_total_q  <= '0;
			disk_total_q <= '0;
			cpu_total_q  <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= in_commit;

			if (in_clear) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end

			if (accept) begin
				res_idx_q <= rat_pkg::RES_RAM;
				fits_q    <= 1'b1;
				op_q      <= req.operation;
			end else if (in_check) begin
				res_idx_q <= res_idx_q + 1'b1;
				fits_q    <= fits_q && unit_fit;
			end

			if (in_commit && success) begin
				ram_total_q  <= ram_cand_q;
				disk_total_q <= disk_cand_q;
				cpu_total_q  <= cpu_cand_q;
			end

			if (cfg_write) begin
				case (paddr[3:2])
					rat_pkg::REG_RAM_LIMIT:  ram_limit_q  <= pwdata[rat_pkg::UNIT_W-1:0];
					rat_pkg::REG_DISK_LIMIT: disk_limit_q <= pwdata[rat_pkg::UNIT_W-1:0];
					rat_pkg::REG_CPU_LIMIT:  cpu_limit_q  <= pwdata[rat_pkg::UNIT_W-1:0];
					default:                 ram_limit_q  <= ram_limit_q;
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Payload registers: the held request, the candidate totals and the
	// result register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q     <= slot_lut[req.app_id];
			ram_dem_q  <= req.ram_demand[DEM_W-1:0];
			disk_dem_q <= req.disk_demand[DEM_W-1:0];
			cpu_dem_q  <= req.cpu_demand[DEM_W-1:0];
		end
		if (in_check) begin
			case (res_idx_q)
				rat_pkg::RES_RAM:  ram_cand_q  <= unit_res[UNIT_BITS-1:0];
				rat_pkg::RES_DISK: disk_cand_q <= unit_res[UNIT_BITS-1:0];
				rat_pkg::RES_CPU:  cpu_cand_q  <= unit_res[UNIT_BITS-1:0];
				default:           ram_cand_q  <= ram_cand_q;
			endcase
		end
		if (in_commit) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
`default_nettype wire

[rtl/rat_checker.sv]
`default_nettype none
`include "resource_admission_table_top_assert.svh"
module rat_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          start,
	input wire logic          busy,
	input wire logic          done,
	input wire rat_pkg::rsp_t rsp
);

	// Grants and releases are the only statuses that pass a request on.
	logic fwd_expected;
	assign fwd_expected = (rsp.status == rat_pkg::STATUS_GRANTED) ||
		(rsp.status == rat_pkg::STATUS_RELEASED);

	// An accepted request keeps the block busy in the following cycle.
	`RAT_ASSERT_NXT(a_accept_busy, start && !busy, busy)
	// A result only appears once the block has returned to idle.
	`RAT_ASSERT_IMP(a_done_idle, done, !busy)
	// Every request gives one result, never two in a row.
	`RAT_ASSERT_NXT(a_done_single, done, !done)
	// Only grants and releases are forwarded.
	`RAT_ASSERT_IMP(a_forward_status, done, rsp.forward == fwd_expected)

endmodule

bind resource_admission_table_top rat_checker u_rat_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
`default_nettype wire
